### hdl/lz_block_decompressor_top_macros.svh
// Assertion macros used by the decompressor core RTL.
`ifndef LZ_BLOCK_DECOMPRESSOR_TOP_MACROS_SVH
`define LZ_BLOCK_DECOMPRESSOR_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define LZBD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lzbd assertion failed");

// next-cycle implication, checked out of reset
`define LZBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lzbd assertion failed");

`endif

### hdl/lzbd_pkg.sv
// Types and constants of the LZ block decompressor.
`default_nettype none
package lzbd_pkg;

  localparam int unsigned WindowBitsDef = 18;
  localparam int unsigned TabDepth      = 52;
  localparam int unsigned TabAw         = 6;
  localparam int unsigned TabDw         = 25;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_DATA = 3'd1;
  localparam logic [2:0] KIND_NEED = 3'd2;
  localparam logic [2:0] KIND_FIN  = 3'd3;
  localparam logic [2:0] KIND_ERR  = 3'd4;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_LEN    = 3'd1;
  localparam logic [2:0] ERR_OFFSET = 3'd2;
  localparam logic [2:0] ERR_UNWR   = 3'd3;
  localparam logic [2:0] ERR_LIMIT  = 3'd4;
  localparam logic [2:0] ERR_TRAIL  = 3'd5;

  typedef enum logic [4:0] {
    PH_SKIP, PH_COUNT, PH_LAST, PH_COMP, PH_TPREFIX, PH_TENTRY, PH_SYM, PH_SLOT,
    PH_RUNLEN, PH_MLEN_RD, PH_MLEN, PH_OCLASS, PH_OVAL_RD, PH_OVAL, PH_LIT,
    PH_COPY_RD, PH_COPY, PH_BLKEND, PH_DONE, PH_ERR
  } phase_e;

  typedef enum logic [2:0] {
    RET_NONE, RET_ACK, RET_NEED, RET_DATA, RET_FIN, RET_FAIL
  } ret_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       blk_end;
    logic [2:0] err;
  } res_t;

endpackage
`default_nettype wire

### hdl/lz_block_decompressor_top.sv
// LZ block decompressor: top level with result register.
//
// Input channel (in_valid_i/in_ready_o) carries one beat per command: func_i 0
// delivers in_byte_i as the next stream byte, func_i 1 asks for one decode step.
// Output channel (out_valid_o/out_ready_i) returns exactly one beat per command:
// kind_o, out_byte_o, block_end_o and error_code_o.
// A delivered byte is answered through the core result register and then the
// output register. A decode step reads the stream one bit at a time, passes
// through each header and symbol phase, and has a memory read phase before each
// table lookup and each window byte copied. A single sequencer steps through
// these phases, fed by the bit shifter.
// Reset returns the decoder to the start of a stream, expecting the checksum
// byte; the window needs no clearing pass, unwritten bytes are tracked by the
// output count.
// While the receiver stalls, one result waits in the output register and one more in
// the core; in_ready_o is low while a command is in progress or its result waits in the core.
`default_nettype none
module lz_block_decompressor_top #(
  parameter int unsigned WINDOW_BITS = lzbd_pkg::WindowBitsDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       func_i,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [2:0]      kind_o,
  output logic [7:0]      out_byte_o,
  output logic            block_end_o,
  output logic [2:0]      error_code_o
);
  import lzbd_pkg::*;

  res_t core_res;
  res_t out_q;
  logic core_valid;
  logic take;
  logic out_valid_q;

  assign take = core_valid && (!out_valid_q || out_ready_i);

  lzbd_core #(.WINDOW_BITS(WINDOW_BITS)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .func_i      (func_i),
    .in_byte_i   (in_byte_i),
    .res_o       (core_res),
    .res_valid_o (core_valid),
    .res_take_i  (take)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= core_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_q.kind;
  assign out_byte_o   = out_q.data;
  assign block_end_o  = out_q.blk_end;
  assign error_code_o = out_q.err;

endmodule
`default_nettype wire

### hdl/lzbd_ram.sv
// Single-port-write, registered-read RAM.
`default_nettype none
module lzbd_ram #(
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### hdl/lzbd_core.sv
// Bit-serial decode sequencer with window and table memories.
`default_nettype none
module lzbd_core #(
  parameter int unsigned WINDOW_BITS = lzbd_pkg::WindowBitsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire logic          func_i,
  input  wire logic [7:0]    in_byte_i,
  output lzbd_pkg::res_t     res_o,
  output logic               res_valid_o,
  input  wire logic          res_take_i
);
  import lzbd_pkg::*;

  localparam int unsigned WB = WINDOW_BITS;

  phase_e         phase_q, phase_d;
  ret_e           ret;
  logic           active_q, active_d;
  logic [7:0]     shift_q, shift_d;
  logic [3:0]     bit_cnt_q, bit_cnt_d;
  logic [8:0]     pend_q, pend_d;
  logic [WB-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [2:0]     far_q, far_d;
  logic [16:0]    syms_q, syms_d, run_q, run_d;
  logic           last_q, last_d;
  logic [24:0]    total_q, total_d;
  logic [15:0]    acc_q, acc_d;
  logic [4:0]     got_q, got_d;
  logic [3:0]     slot_q, slot_d;
  logic [5:0]     tidx_q, tidx_d;
  logic [20:0]    tsum_q, tsum_d;
  logic [2:0]     err_q, err_d;
  res_t           res_q, res_d;
  logic           res_valid_q;

  logic           accept;
  logic           bit_ph;
  logic [4:0]     n_sel;
  logic           avail, bit_b, consume, fld_done;
  logic [15:0]    fld_val;
  logic [7:0]     ret_byte;
  logic           ret_end;
  logic           win_we;
  logic [7:0]     win_rd;
  logic           tab_we;
  logic [TabAw-1:0] tab_raddr;
  logic [TabDw-1:0] tab_rd, tab_wdata;
  logic [3:0]     t_bits;
  logic [20:0]    t_base;
  logic [20:0]    sum_eff;
  logic [21:0]    v22;
  logic           written;
  logic [16:0]    run_nx;

  assign accept      = req_valid_i && req_ready_o;
  assign req_ready_o = !active_q && !res_valid_q;
  assign t_bits      = tab_rd[24:21];
  assign t_base      = tab_rd[20:0];

  assign avail   = (bit_cnt_q != 4'd0) || pend_q[8];
  assign bit_b   = (bit_cnt_q != 4'd0) ? shift_q[7] : pend_q[7];
  assign written = (total_q[24:WB] != '0) || (25'(rp_q) < total_q);
  assign sum_eff = (tidx_q == 6'd8 || tidx_q == 6'd12 || tidx_q == 6'd20) ? 21'd0 : tsum_q;

  always_comb begin
    bit_ph = 1'b1;
    n_sel  = 5'd0;
    case (phase_q)
      PH_COUNT:   n_sel = 5'd16;
      PH_LAST:    n_sel = 5'd1;
      PH_COMP:    n_sel = 5'd1;
      PH_TPREFIX: n_sel = 5'd2;
      PH_TENTRY:  n_sel = 5'd4;
      PH_SLOT:    n_sel = 5'd1;
      PH_RUNLEN:  n_sel = 5'd8;
      PH_MLEN:    n_sel = {1'b0, t_bits};
      PH_OVAL:    n_sel = {1'b0, t_bits};
      PH_OCLASS: begin
        if (run_q == 17'd1) begin
          n_sel = 5'd2;
        end else if (run_q == 17'd2) begin
          n_sel = 5'd3;
        end else begin
          n_sel = {2'b0, far_q};
        end
      end
      default:    bit_ph = 1'b0;
    endcase
  end

  assign consume  = active_q && bit_ph && (n_sel != 5'd0) && avail;
  assign fld_done = (n_sel == 5'd0) || (avail && (got_q + 5'd1 == n_sel));
  assign fld_val  = (n_sel == 5'd0) ? 16'd0 : {acc_q[14:0], bit_b};
  assign run_nx   = (run_q != 17'd0) ? run_q - 17'd1 : 17'd0;

  // next state and datapath
  always_comb begin
    phase_d   = phase_q;
    active_d  = active_q;
    shift_d   = shift_q;
    bit_cnt_d = bit_cnt_q;
    pend_d    = pend_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    far_d     = far_q;
    syms_d    = syms_q;
    run_d     = run_q;
    last_d    = last_q;
    total_d   = total_q;
    acc_d     = acc_q;
    got_d     = got_q;
    slot_d    = slot_q;
    tidx_d    = tidx_q;
    tsum_d    = tsum_q;
    err_d     = err_q;
    ret       = RET_NONE;
    ret_byte  = 8'd0;
    ret_end   = 1'b0;
    tab_we    = 1'b0;
    v22       = 22'd0;

    if (consume) begin
      if (bit_cnt_q == 4'd0) begin
        shift_d   = {pend_q[6:0], 1'b0};
        bit_cnt_d = 4'd7;
        pend_d    = 9'd0;
      end else begin
        shift_d   = {shift_q[6:0], 1'b0};
        bit_cnt_d = bit_cnt_q - 4'd1;
      end
      if (fld_done) begin
        acc_d = 16'd0;
        got_d = 5'd0;
      end else begin
        acc_d = fld_val;
        got_d = got_q + 5'd1;
      end
    end

    if (accept) begin
      if (!func_i) begin
        ret = RET_ACK;
        if (phase_q == PH_DONE) begin
          phase_d = PH_ERR;
          err_d   = ERR_TRAIL;
        end else if (phase_q != PH_ERR) begin
          pend_d = {1'b1, in_byte_i};
        end
      end else begin
        active_d = 1'b1;
      end
    end else if (active_q) begin
      if (bit_ph && !fld_done) begin
        if (!avail) begin
          ret = RET_NEED;
        end
      end else begin
        case (phase_q)
          PH_SKIP: begin
            if (pend_q[8]) begin
              pend_d  = 9'd0;
              phase_d = PH_COUNT;
            end else begin
              ret = RET_NEED;
            end
          end
          PH_COUNT: begin
            syms_d  = {1'b0, fld_val} + 17'd1;
            phase_d = PH_LAST;
          end
          PH_LAST: begin
            last_d  = fld_val[0];
            phase_d = PH_COMP;
          end
          PH_COMP: begin
            if (!fld_val[0]) begin
              run_d   = syms_q;
              syms_d  = 17'd0;
              phase_d = PH_LIT;
            end else begin
              phase_d = PH_TPREFIX;
            end
          end
          PH_TPREFIX: begin
            far_d   = {1'b0, fld_val[1:0]} + 3'd2;
            tidx_d  = 6'd0;
            tsum_d  = 21'd0;
            phase_d = PH_TENTRY;
          end
          PH_TENTRY: begin
            tab_we = 1'b1;
            tsum_d = sum_eff + (21'd1 << fld_val[3:0]);
            tidx_d = tidx_q + 6'd1;
            if ((7'(tidx_q) + 7'd1) >= (7'd20 + (7'd1 << far_q))) begin
              phase_d = PH_SYM;
            end
          end
          PH_SYM: begin
            if (syms_q == 17'd0) begin
              phase_d = PH_BLKEND;
            end else begin
              syms_d  = syms_q - 17'd1;
              slot_d  = 4'd0;
              phase_d = PH_SLOT;
            end
          end
          PH_SLOT: begin
            if (fld_val[0]) begin
              slot_d = slot_q + 4'd1;
              if (slot_q + 4'd1 >= 4'd9) begin
                phase_d = PH_RUNLEN;
              end
            end else if (slot_q == 4'd0) begin
              run_d   = 17'd1;
              phase_d = PH_LIT;
            end else begin
              phase_d = PH_MLEN_RD;
            end
          end
          PH_RUNLEN: begin
            run_d   = {9'd0, fld_val[7:0]} + 17'd17;
            phase_d = PH_LIT;
          end
          PH_MLEN_RD: phase_d = PH_MLEN;
          PH_MLEN: begin
            v22 = {1'b0, t_base} + {6'd0, fld_val} + 22'd1;
            if (v22 > 22'd65535) begin
              phase_d = PH_ERR;
              err_d   = ERR_LEN;
              ret     = RET_FAIL;
            end else begin
              run_d   = v22[16:0];
              phase_d = PH_OCLASS;
            end
          end
          PH_OCLASS: begin
            if (run_q == 17'd1) begin
              tidx_d = 6'd8 + 6'(fld_val[4:0]);
            end else if (run_q == 17'd2) begin
              tidx_d = 6'd12 + 6'(fld_val[4:0]);
            end else begin
              tidx_d = 6'd20 + 6'(fld_val[4:0]);
            end
            phase_d = PH_OVAL_RD;
          end
          PH_OVAL_RD: phase_d = PH_OVAL;
          PH_OVAL: begin
            v22 = {1'b0, t_base} + {6'd0, fld_val};
            if ((v22 >> WB) != 22'd0) begin
              phase_d = PH_ERR;
              err_d   = ERR_OFFSET;
              ret     = RET_FAIL;
            end else begin
              rp_d    = wp_q - v22[WB-1:0] - {{(WB-1){1'b0}}, 1'b1};
              phase_d = PH_COPY_RD;
            end
          end
          PH_COPY_RD: phase_d = PH_COPY;
          PH_LIT, PH_COPY: begin
            if (phase_q == PH_LIT && !pend_q[8]) begin
              ret = RET_NEED;
            end else if (phase_q == PH_COPY && !written) begin
              phase_d = PH_ERR;
              err_d   = ERR_UNWR;
              ret     = RET_FAIL;
            end else if (total_q[24]) begin
              phase_d = PH_ERR;
              err_d   = ERR_LIMIT;
              ret     = RET_FAIL;
            end else begin
              ret      = RET_DATA;
              ret_byte = (phase_q == PH_LIT) ? pend_q[7:0] : win_rd;
              if (phase_q == PH_LIT) begin
                pend_d = 9'd0;
              end else begin
                rp_d = rp_q + {{(WB-1){1'b0}}, 1'b1};
              end
              wp_d    = wp_q + {{(WB-1){1'b0}}, 1'b1};
              total_d = total_q + 25'd1;
              run_d   = run_nx;
              ret_end = (run_nx == 17'd0) && (syms_q == 17'd0);
              if (run_nx == 17'd0) begin
                phase_d = (syms_q == 17'd0) ? PH_BLKEND : PH_SYM;
              end else if (phase_q == PH_COPY) begin
                phase_d = PH_COPY_RD;
              end
            end
          end
          PH_BLKEND: begin
            if (last_q) begin
              if (shift_q != 8'd0 || pend_q[8]) begin
                phase_d = PH_ERR;
                err_d   = ERR_TRAIL;
                ret     = RET_FAIL;
              end else begin
                phase_d = PH_DONE;
                ret     = RET_FIN;
              end
            end else begin
              phase_d = PH_COUNT;
            end
          end
          PH_DONE: ret = RET_FIN;
          default: begin
            phase_d = PH_ERR;
            ret     = RET_FAIL;
          end
        endcase
      end
      if (ret != RET_NONE) begin
        active_d = 1'b0;
      end
    end
  end

  // result and memory write outputs
  always_comb begin
    res_d  = '0;
    win_we = 1'b0;
    case (ret)
      RET_NEED: res_d.kind = KIND_NEED;
      RET_FIN:  res_d.kind = KIND_FIN;
      RET_FAIL: begin
        res_d.kind = KIND_ERR;
        res_d.err  = err_d;
      end
      RET_DATA: begin
        res_d.kind    = KIND_DATA;
        res_d.data    = ret_byte;
        res_d.blk_end = ret_end;
        win_we        = 1'b1;
      end
      default:  res_d.kind = KIND_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SKIP;
      active_q    <= 1'b0;
      shift_q     <= 8'd0;
      bit_cnt_q   <= 4'd0;
      pend_q      <= 9'd0;
      wp_q        <= '0;
      rp_q        <= '0;
      far_q       <= 3'd2;
      syms_q      <= 17'd0;
      run_q       <= 17'd0;
      last_q      <= 1'b0;
      total_q     <= 25'd0;
      acc_q       <= 16'd0;
      got_q       <= 5'd0;
      slot_q      <= 4'd0;
      tidx_q      <= 6'd0;
      tsum_q      <= 21'd0;
      err_q       <= ERR_NONE;
      res_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      active_q  <= active_d;
      shift_q   <= shift_d;
      bit_cnt_q <= bit_cnt_d;
      pend_q    <= pend_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      far_q     <= far_d;
      syms_q    <= syms_d;
      run_q     <= run_d;
      last_q    <= last_d;
      total_q   <= total_d;
      acc_q     <= acc_d;
      got_q     <= got_d;
      slot_q    <= slot_d;
      tidx_q    <= tidx_d;
      tsum_q    <= tsum_d;
      err_q     <= err_d;
      if (ret != RET_NONE) begin
        res_valid_q <= 1'b1;
      end else if (res_take_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ret != RET_NONE) begin
      res_q <= res_d;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  assign tab_raddr = (phase_q == PH_MLEN_RD || phase_q == PH_MLEN)
                   ? {3'd0, slot_q[2:0] - 3'd1} : tidx_q;
  assign tab_wdata = {fld_val[3:0], sum_eff};

  lzbd_ram #(.AW(TabAw), .DW(TabDw), .DEPTH(TabDepth)) u_tab (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tidx_q),
    .wdata_i (tab_wdata),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rd)
  );

  lzbd_ram #(.AW(WB), .DW(8), .DEPTH(1 << WB)) u_win (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (wp_q),
    .wdata_i (ret_byte),
    .raddr_i (rp_q),
    .rdata_o (win_rd)
  );

  `include "lz_block_decompressor_top_macros.svh"

  `LZBD_ASSERT_IMPL(a_bit_cnt_range, 1'b1, bit_cnt_q <= 4'd8)
  `LZBD_ASSERT_IMPL(a_res_ends_item, res_valid_q, !active_q)
  `LZBD_ASSERT_IMPL(a_err_coded, phase_q == PH_ERR, err_q != ERR_NONE)
  `LZBD_ASSERT_NEXT(a_fail_sticks, phase_q == PH_ERR, phase_q == PH_ERR)

endmodule
`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the LZ block decompressor top level.
`timescale 1ns / 1ps
module tb;
  import lzbd_pkg::*;

  typedef enum int {
    ST_SKIP, ST_COUNT, ST_LAST, ST_COMP, ST_TPREFIX, ST_TENTRY, ST_SYM, ST_SLOT,
    ST_RUNLEN, ST_MLEN, ST_OCLASS, ST_OVAL, ST_LIT, ST_COPY, ST_BLKEND, ST_DONE, ST_ERR
  } dec_state_e;

  typedef enum int {END_CLEAN, END_TRAIL, END_LEN, END_OFF, END_UNWR} ending_e;

  typedef struct {
    bit         func;
    logic [7:0] data;
  } cmd_t;

  localparam int WinSize = 1 << WindowBitsDef;
  localparam int WinMask = WinSize - 1;

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_func = 1'b0;
  logic [7:0] in_byte = 8'd0;
  logic       out_ready = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [2:0] kind_o;
  logic [7:0] out_byte_o;
  logic       block_end_o;
  logic [2:0] error_code_o;

  lz_block_decompressor_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .func_i       (in_func),
    .in_byte_i    (in_byte),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .kind_o       (kind_o),
    .out_byte_o   (out_byte_o),
    .block_end_o  (block_end_o),
    .error_code_o (error_code_o)
  );

  always #5 clk_i = ~clk_i;

  // decoder state
  dec_state_e  dec_state = ST_SKIP;
  logic [7:0]  shift_reg = 8'd0;
  int          shift_cnt = 0;
  bit          held_valid = 1'b0;
  logic [7:0]  held_byte = 8'd0;
  logic [7:0]  window_mem [WinSize];
  bit          window_ok [WinSize];
  int          wr_ptr = 0;
  int          rd_ptr = 0;
  logic [3:0]  len_bits [TabDepth];
  logic [20:0] len_base [TabDepth];
  int          far_bits = 2;
  int          syms_left = 0;
  int          run_left = 0;
  bit          last_block = 1'b0;
  int          out_total = 0;
  logic [20:0] field_acc = 21'd0;
  int          field_got = 0;
  int          slot_cnt = 0;
  int          tab_idx = 0;
  logic [20:0] tab_sum = 21'd0;
  logic [2:0]  sticky_err = ERR_NONE;

  res_t expected_q [$];
  cmd_t cmd_q [$];
  int   n_accepted = 0;
  logic [2:0] last_kind = KIND_NONE;
  int   err_cnt = 0;
  int   n_data = 0;
  int   n_block_ends = 0;
  bit   long_hold = 1'b0;

  function automatic res_t mk(logic [2:0] k, logic [7:0] d, logic e, logic [2:0] c);
    res_t r;
    r.kind = k;
    r.data = d;
    r.blk_end = e;
    r.err = c;
    return r;
  endfunction

  function automatic res_t fail_with(logic [2:0] code);
    dec_state = ST_ERR;
    sticky_err = code;
    return mk(KIND_ERR, 8'd0, 1'b0, code);
  endfunction

  function automatic int pull_bit();
    int b;
    if (shift_cnt == 0) begin
      if (!held_valid) return -1;
      shift_reg = held_byte;
      held_valid = 1'b0;
      shift_cnt = 8;
    end
    b = shift_reg[7];
    shift_reg = {shift_reg[6:0], 1'b0};
    shift_cnt--;
    return b;
  endfunction

  function automatic bit pull_field(int n, output logic [20:0] v);
    int b;
    v = 21'd0;
    while (field_got < n) begin
      b = pull_bit();
      if (b < 0) return 1'b0;
      field_acc = {field_acc[19:0], b[0]};
      field_got++;
    end
    v = field_acc;
    field_acc = 21'd0;
    field_got = 0;
    return 1'b1;
  endfunction

  function automatic res_t emit_byte(logic [7:0] b);
    logic e;
    if (out_total >= 16777216) return fail_with(ERR_LIMIT);
    window_mem[wr_ptr] = b;
    window_ok[wr_ptr] = 1'b1;
    wr_ptr = (wr_ptr + 1) & WinMask;
    out_total++;
    if (run_left != 0) run_left--;
    e = (run_left == 0 && syms_left == 0);
    if (run_left == 0) dec_state = (syms_left == 0) ? ST_BLKEND : ST_SYM;
    return mk(KIND_DATA, b, e, ERR_NONE);
  endfunction

  function automatic res_t decode_beat(bit f, logic [7:0] b);
    logic [20:0] v;
    int val, e, n;
    res_t need;
    need = mk(KIND_NEED, 8'd0, 1'b0, ERR_NONE);
    if (!f) begin
      if (dec_state == ST_DONE) begin
        dec_state = ST_ERR;
        sticky_err = ERR_TRAIL;
      end else if (dec_state != ST_ERR) begin
        held_valid = 1'b1;
        held_byte = b;
      end
      return mk(KIND_NONE, 8'd0, 1'b0, ERR_NONE);
    end
    while (1) begin
      case (dec_state)
        ST_SKIP: begin
          if (!held_valid) return need;
          held_valid = 1'b0;
          dec_state = ST_COUNT;
        end
        ST_COUNT: begin
          if (!pull_field(16, v)) return need;
          syms_left = v + 1;
          dec_state = ST_LAST;
        end
        ST_LAST: begin
          if (!pull_field(1, v)) return need;
          last_block = v[0];
          dec_state = ST_COMP;
        end
        ST_COMP: begin
          if (!pull_field(1, v)) return need;
          if (v == 0) begin
            run_left = syms_left;
            syms_left = 0;
            dec_state = ST_LIT;
          end else begin
            dec_state = ST_TPREFIX;
          end
        end
        ST_TPREFIX: begin
          if (!pull_field(2, v)) return need;
          far_bits = v + 2;
          tab_idx = 0;
          tab_sum = 21'd0;
          dec_state = ST_TENTRY;
        end
        ST_TENTRY: begin
          if (tab_idx == 8 || tab_idx == 12 || tab_idx == 20) tab_sum = 21'd0;
          if (!pull_field(4, v)) return need;
          if (tab_idx < TabDepth) begin
            len_bits[tab_idx] = v[3:0];
            len_base[tab_idx] = tab_sum;
          end
          tab_sum = tab_sum + (21'd1 << v[3:0]);
          tab_idx++;
          if (tab_idx >= 20 + (1 << far_bits)) dec_state = ST_SYM;
        end
        ST_SYM: begin
          if (syms_left == 0) begin
            dec_state = ST_BLKEND;
          end else begin
            syms_left--;
            slot_cnt = 0;
            dec_state = ST_SLOT;
          end
        end
        ST_SLOT: begin
          if (!pull_field(1, v)) return need;
          if (v != 0) slot_cnt++;
          if (v == 0 || slot_cnt >= 9) begin
            if (slot_cnt == 0) begin
              run_left = 1;
              dec_state = ST_LIT;
            end else if (slot_cnt >= 9) begin
              dec_state = ST_RUNLEN;
            end else begin
              dec_state = ST_MLEN;
            end
          end
        end
        ST_RUNLEN: begin
          if (!pull_field(8, v)) return need;
          run_left = v + 17;
          dec_state = ST_LIT;
        end
        ST_MLEN: begin
          e = (slot_cnt - 1) & 7;
          if (!pull_field(len_bits[e], v)) return need;
          val = len_base[e] + v + 1;
          if (val > 65535) return fail_with(ERR_LEN);
          run_left = val;
          dec_state = ST_OCLASS;
        end
        ST_OCLASS: begin
          if (run_left == 1) begin
            n = 2; e = 8;
          end else if (run_left == 2) begin
            n = 3; e = 12;
          end else begin
            n = far_bits; e = 20;
          end
          if (!pull_field(n, v)) return need;
          tab_idx = e + v;
          if (tab_idx >= TabDepth) tab_idx = TabDepth - 1;
          dec_state = ST_OVAL;
        end
        ST_OVAL: begin
          if (!pull_field(len_bits[tab_idx], v)) return need;
          val = len_base[tab_idx] + v;
          if (val >= WinSize) return fail_with(ERR_OFFSET);
          rd_ptr = (wr_ptr - val - 1) & WinMask;
          dec_state = ST_COPY;
        end
        ST_LIT: begin
          if (!held_valid) return need;
          held_valid = 1'b0;
          return emit_byte(held_byte);
        end
        ST_COPY: begin
          if (!window_ok[rd_ptr]) return fail_with(ERR_UNWR);
          val = rd_ptr;
          rd_ptr = (rd_ptr + 1) & WinMask;
          return emit_byte(window_mem[val]);
        end
        ST_BLKEND: begin
          if (last_block) begin
            if (shift_reg != 0 || held_valid) return fail_with(ERR_TRAIL);
            dec_state = ST_DONE;
            return mk(KIND_FIN, 8'd0, 1'b0, ERR_NONE);
          end
          dec_state = ST_COUNT;
        end
        ST_DONE: return mk(KIND_FIN, 8'd0, 1'b0, ERR_NONE);
        default: begin
          dec_state = ST_ERR;
          return mk(KIND_ERR, 8'd0, 1'b0, sticky_err);
        end
      endcase
    end
  endfunction

  // stream encoder
  logic [7:0] stream_q [$];
  int enc_total = 0;
  int bit_byte_idx = 0;
  int bits_free = 0;
  int enc_bits [TabDepth];
  int enc_base [TabDepth];

  task automatic put_bits(int n, int val);
    for (int i = n - 1; i >= 0; i--) begin
      if (bits_free == 0) begin
        stream_q.push_back(8'd0);
        bit_byte_idx = stream_q.size() - 1;
        bits_free = 8;
      end
      stream_q[bit_byte_idx][bits_free - 1] = val[i];
      bits_free--;
    end
  endtask

  task automatic put_literal();
    stream_q.push_back($urandom_range(0, 255));
    enc_total++;
  endtask

  task automatic put_tables(int p);
    int s;
    s = 0;
    put_bits(2, p);
    for (int i = 0; i < 20 + (1 << (p + 2)); i++) begin
      if (i == 8 || i == 12 || i == 20) s = 0;
      enc_base[i] = s;
      s += 1 << enc_bits[i];
      put_bits(4, enc_bits[i]);
    end
  endtask

  task automatic clear_tables();
    for (int i = 0; i < TabDepth; i++) enc_bits[i] = 0;
  endtask

  task automatic encode_block(bit last);
    int nsym, p, t, k, slot, e, v, len, e0, n, idx, v2, off;
    bit comp, ok;
    comp = ($urandom_range(0, 2) != 0);
    nsym = comp ? $urandom_range(1, 20) : $urandom_range(1, 12);
    put_bits(16, nsym - 1);
    put_bits(1, last);
    put_bits(1, comp);
    if (!comp) begin
      repeat (nsym) put_literal();
    end else begin
      p = $urandom_range(0, 3);
      for (int i = 0; i < TabDepth; i++)
        enc_bits[i] = (i < 8) ? $urandom_range(0, 3) : $urandom_range(0, 4);
      put_tables(p);
      for (int s = 0; s < nsym; s++) begin
        t = $urandom_range(0, 9);
        ok = 1'b0;
        if (t >= 5 && enc_total > 0) begin
          slot = $urandom_range(1, 8);
          e = slot - 1;
          v = $urandom_range(0, (1 << enc_bits[e]) - 1);
          len = enc_base[e] + v + 1;
          if (len == 1) begin
            e0 = 8; n = 2;
          end else if (len == 2) begin
            e0 = 12; n = 3;
          end else begin
            e0 = 20; n = p + 2;
          end
          idx = e0 + $urandom_range(0, (1 << n) - 1);
          v2 = $urandom_range(0, (1 << enc_bits[idx]) - 1);
          off = enc_base[idx] + v2;
          ok = (off < enc_total);
        end
        if (ok) begin
          put_bits(slot + 1, ((1 << slot) - 1) << 1);
          put_bits(enc_bits[e], v);
          put_bits(n, idx - e0);
          put_bits(enc_bits[idx], v2);
          enc_total += len;
        end else if (t == 4) begin
          k = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 15);
          put_bits(9, 'h1FF);
          put_bits(8, k);
          repeat (17 + k) put_literal();
        end else begin
          put_bits(1, 0);
          put_literal();
        end
      end
    end
  endtask

  task automatic encode_final(ending_e mode);
    if (mode == END_CLEAN || mode == END_TRAIL) begin
      encode_block(1'b1);
      if (mode == END_TRAIL && bits_free > 0) stream_q[bit_byte_idx][0] = 1'b1;
    end else begin
      put_bits(16, 0);
      put_bits(1, 1);
      put_bits(1, 1);
      clear_tables();
      case (mode)
        END_LEN: begin
          for (int i = 0; i < 7; i++) enc_bits[i] = 15;
          put_tables(0);
          put_bits(9, 'h1FE);
        end
        END_OFF: begin
          enc_bits[0] = 2;
          for (int i = 20; i < TabDepth; i++) enc_bits[i] = 15;
          put_tables(3);
          put_bits(2, 'b10);
          put_bits(2, 2);
          put_bits(5, 9);
          put_bits(15, 0);
        end
        default: begin
          for (int i = 8; i < 12; i++) enc_bits[i] = 15;
          put_tables(0);
          put_bits(2, 'b10);
          put_bits(2, 3);
          put_bits(15, 0);
        end
      endcase
    end
  endtask

  // sender
  int gap_left = 0;
  int burst_left = 0;
  cmd_t next_cmd;
  res_t pred_r;

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_func <= 1'b0;
      in_byte <= 8'd0;
    end else begin
      if (in_valid && in_ready_o) begin
        pred_r = decode_beat(in_func, in_byte);
        expected_q.push_back(pred_r);
        last_kind = pred_r.kind;
        n_accepted++;
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          next_cmd = cmd_q.pop_front();
          in_valid <= 1'b1;
          in_func <= next_cmd.func;
          in_byte <= next_cmd.data;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  int stall_mode = 0;
  int stall_left = 0;
  res_t want;

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = expected_q.pop_front();
          if (kind_o !== want.kind)
            report($sformatf("kind %0d, expected %0d", kind_o, want.kind));
          if (out_byte_o !== want.data)
            report($sformatf("out_byte %0h, expected %0h", out_byte_o, want.data));
          if (block_end_o !== want.blk_end)
            report($sformatf("block_end %0b, expected %0b", block_end_o, want.blk_end));
          if (error_code_o !== want.err)
            report($sformatf("error_code %0d, expected %0d", error_code_o, want.err));
          if (want.kind == KIND_DATA) n_data++;
          if (want.blk_end) n_block_ends++;
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(16, 96);
      end else begin
        stall_left--;
      end
      if (long_hold) out_ready <= 1'b0;
      else if (stall_mode == 0) out_ready <= 1'b1;
      else if (stall_mode == 1) out_ready <= $urandom_range(0, 1);
      else out_ready <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    wait (n_accepted >= 200);
    long_hold = 1'b1;
    repeat (300) @(posedge clk_i);
    long_hold = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("lz_block_decompressor_top verification failed");
    $finish;
  end

  task automatic send(bit f, logic [7:0] b);
    cmd_t c;
    int target;
    c.func = f;
    c.data = b;
    target = n_accepted + 1;
    cmd_q.push_back(c);
    wait (n_accepted >= target);
  endtask

  initial begin
    ending_e mode;
    int fed;
    bit paused;
    mode = ending_e'($urandom_range(0, 4));
    fed = 0;
    paused = 1'b0;
    while (2 * stream_q.size() + enc_total < 850) encode_block(1'b0);
    encode_final(mode);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // step before any byte, then a byte replaced by the checksum byte
    send(1'b1, 8'd0);
    send(1'b0, 8'h00);
    send(1'b0, 8'hFF);
    send(1'b1, 8'd0);

    while (1) begin
      if (!paused && fed >= stream_q.size() / 2) begin
        wait (expected_q.size() == 0);
        paused = 1'b1;
      end
      if (!held_valid && fed < stream_q.size() && $urandom_range(0, 4) == 0)
        send(1'b0, stream_q[fed++]);
      send(1'b1, 8'd0);
      if (last_kind == KIND_NEED) begin
        if (fed >= stream_q.size()) break;
        send(1'b0, stream_q[fed++]);
      end else if (last_kind == KIND_FIN || last_kind == KIND_ERR) begin
        break;
      end
    end

    // beats after the stream has ended
    send(1'b1, 8'd0);
    send(1'b0, $urandom_range(0, 255));
    send(1'b1, 8'd0);
    send(1'b0, $urandom_range(0, 255));
    send(1'b1, 8'd0);

    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("Run covered %0d commands, %0d data bytes over %0d blocks, ending %s.",
             n_accepted, n_data, n_block_ends, mode.name());
    if (err_cnt == 0) begin
      $display("lz_block_decompressor_top verification clean");
    end else begin
      $display("lz_block_decompressor_top verification failed");
    end
    $finish;
  end

endmodule
